FILE: rtl/bitmap_first_fit_allocator_macros.svh
// Assertion macros for the bitmap first-fit allocator.
// Bodies refer to clk and rst of the including module.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BFFA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication.
`define BFFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

FILE: rtl/bffa_pkg.sv
// Shared constants, codes and word-unit interface types for the allocator.
// No dependencies.
package bffa_pkg;

  localparam int POOL_UNITS = 1024;
  localparam int WORD_BITS = 8;
  localparam int MAP_WORDS = POOL_UNITS / WORD_BITS;
  localparam int UNIT_W    = $clog2(POOL_UNITS);
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int COUNT_W   = UNIT_W + 1;
  localparam int CNT_W     = BIT_W + 1;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL_FREE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    WU_SCAN,
    WU_MARK,
    WU_CLEAR
  } wu_op_t;

  typedef struct packed {
    wu_op_t             op;
    logic [BIT_W-1:0]   lo;
    logic [BIT_W-1:0]   hi;
    logic [COUNT_W-1:0] run;
    logic [COUNT_W-1:0] need;
  } wu_ctrl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic                 found;
    logic [BIT_W-1:0]     pos;
    logic [COUNT_W-1:0]   run;
    logic                 stop;
    logic [CNT_W-1:0]     cnt;
  } wu_res_t;

endpackage

FILE: rtl/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator: sequencer, allocation map memory, used count.
// Depends on bffa_pkg, bffa_word_unit and bitmap_first_fit_allocator_macros.svh.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   request  | start, busy         | func, size, block_index, block_null
//   result   | done (1-cycle pulse)| status, start_index, used_count
//
// Map is read one 8-unit word per cycle through the shared word unit.
// Allocate scans map words until a free run is long enough, then marks the run's words.
// Free walks words from the block's word until its run of set units ends; a null free
// answers in the next cycle.
// Reset clears the map through per-word valid bits; no sweep is needed.
// Results cannot be stalled; busy is low again in the cycle done is high.
`include "bitmap_first_fit_allocator_macros.svh"

module bitmap_first_fit_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [bffa_pkg::UNIT_W-1:0]     size,
  input  logic [bffa_pkg::UNIT_W-1:0]     block_index,
  input  logic                            block_null,
  output logic                            done,
  output logic [bffa_pkg::STATUS_W-1:0]   status,
  output logic [bffa_pkg::UNIT_W-1:0]     start_index,
  output logic [bffa_pkg::COUNT_W-1:0]    used_count
);
  import bffa_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    MARK,
    CLEAR
  } state_t;

  state_t               state;
  logic [ADDR_W:0]      addr;
  logic [ADDR_W-1:0]    cur;
  logic                 pend;
  logic [COUNT_W-1:0]   run;
  logic [COUNT_W-1:0]   need;
  logic [UNIT_W-1:0]    size_q;
  logic [UNIT_W-1:0]    bidx_q;
  logic [UNIT_W-1:0]    start_u;
  logic [UNIT_W-1:0]    last_u;
  logic [COUNT_W-1:0]   used_units;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_valid;
  logic                 wr_en;

  wu_ctrl_t             wu_ctrl;
  wu_res_t              wu_res;
  logic [UNIT_W-1:0]    end_u;
  logic [UNIT_W-1:0]    start_calc;
  logic [UNIT_W-1:0]    last_calc;

  bffa_word_unit u_word_unit (
    .ctrl (wu_ctrl),
    .data (rd_valid ? rd_word : '0),
    .res  (wu_res)
  );

  always_comb begin
    case (state)
      MARK:    wu_ctrl.op = WU_MARK;
      CLEAR:   wu_ctrl.op = WU_CLEAR;
      default: wu_ctrl.op = WU_SCAN;
    endcase
    if (state == CLEAR) begin
      wu_ctrl.lo = (cur == bidx_q[UNIT_W-1:BIT_W]) ? bidx_q[BIT_W-1:0] : '0;
    end else begin
      wu_ctrl.lo = (cur == start_u[UNIT_W-1:BIT_W]) ? start_u[BIT_W-1:0] : '0;
    end
    wu_ctrl.hi   = (cur == last_u[UNIT_W-1:BIT_W]) ? last_u[BIT_W-1:0] : '1;
    wu_ctrl.run  = run;
    wu_ctrl.need = need;
  end

  assign end_u      = {cur, wu_res.pos};
  assign start_calc = end_u - size_q;
  assign last_calc  = end_u - 1'b1;
  assign wr_en      = pend && (state == MARK || state == CLEAR);
  assign busy       = (state != IDLE);
  assign used_count = used_units;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur] <= wu_res.data;
    end
    rd_word  <= mem[addr[ADDR_W-1:0]];
    rd_valid <= valid[addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[cur] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      addr       <= '0;
      pend       <= 1'b0;
      done       <= 1'b0;
      used_units <= '0;
    end else begin
      done <= 1'b0;
      // advance the read address one word a cycle
      if (state != IDLE && !addr[ADDR_W]) begin
        cur  <= addr[ADDR_W-1:0];
        addr <= addr + 1'b1;
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (start) begin
            size_q <= size;
            bidx_q <= block_index;
            need   <= COUNT_W'(size) + COUNT_W'(2);
            run    <= '0;
            if (func == FUNC_ALLOC) begin
              state <= SCAN;
              addr  <= '0;
            end else if (block_null) begin
              done        <= 1'b1;
              status      <= ST_NULL_FREE;
              start_index <= '0;
            end else begin
              state <= CLEAR;
              addr  <= {1'b0, block_index[UNIT_W-1:BIT_W]};
            end
          end
        end
        SCAN: begin
          if (pend) begin
            if (wu_res.found) begin
              start_index <= start_calc;
              start_u     <= start_calc;
              last_u      <= last_calc;
              if (size_q == '0) begin
                state  <= IDLE;
                done   <= 1'b1;
                status <= ST_OK;
              end else begin
                state <= MARK;
                addr  <= {1'b0, start_calc[UNIT_W-1:BIT_W]};
                pend  <= 1'b0;
              end
            end else begin
              run <= wu_res.run;
              if (cur == ADDR_W'(MAP_WORDS - 1)) begin
                state       <= IDLE;
                done        <= 1'b1;
                status      <= ST_NO_SPACE;
                start_index <= '0;
              end
            end
          end
        end
        MARK: begin
          if (pend && cur == last_u[UNIT_W-1:BIT_W]) begin
            state      <= IDLE;
            done       <= 1'b1;
            status     <= ST_OK;
            used_units <= used_units + COUNT_W'(size_q);
          end
        end
        CLEAR: begin
          if (pend) begin
            used_units <= used_units - COUNT_W'(wu_res.cnt);
            if (wu_res.stop || cur == ADDR_W'(MAP_WORDS - 1)) begin
              state       <= IDLE;
              done        <= 1'b1;
              status      <= ST_OK;
              start_index <= '0;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `BFFA_ASSERT_IMPLY(a_done_idle, done, !busy)
  `BFFA_ASSERT_IMPLY(a_used_bound, 1'b1, used_units <= COUNT_W'(POOL_UNITS))
  `BFFA_ASSERT_NEXT(a_alloc_scan, start && !busy && func == FUNC_ALLOC, state == SCAN)
  `BFFA_ASSERT_IMPLY(a_mark_range, state == MARK && pend, cur <= last_u[UNIT_W-1:BIT_W])
  `BFFA_ASSERT_IMPLY(a_fail_zero, done && status != ST_OK, start_index == '0)

endmodule

FILE: rtl/bffa_word_unit.sv
// Shared map-word unit: free-run scan, mark mask and clear walk on one word.
// Depends on bffa_pkg.
module bffa_word_unit (
  input  bffa_pkg::wu_ctrl_t                   ctrl,
  input  logic [bffa_pkg::WORD_BITS-1:0]       data,
  output bffa_pkg::wu_res_t                    res
);
  import bffa_pkg::*;

  logic [COUNT_W-1:0]   r;
  logic                 hit;
  logic                 go;
  logic [BIT_W-1:0]     p;
  logic [WORD_BITS-1:0] mmask;
  logic [WORD_BITS-1:0] cmask;
  logic [CNT_W-1:0]     n;

  // Unit order is MSB first within a word.
  always_comb begin
    r     = ctrl.run;
    hit   = 1'b0;
    p     = '0;
    go    = 1'b1;
    mmask = '0;
    cmask = '0;
    n     = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!hit) begin
        if (data[WORD_BITS-1-b]) begin
          r = '0;
        end else begin
          r = r + 1'b1;
        end
        if (r == ctrl.need) begin
          hit = 1'b1;
          p   = BIT_W'(b);
        end
      end
      if (BIT_W'(b) >= ctrl.lo && BIT_W'(b) <= ctrl.hi) begin
        mmask[WORD_BITS-1-b] = 1'b1;
      end
      if (BIT_W'(b) >= ctrl.lo) begin
        if (go && data[WORD_BITS-1-b]) begin
          cmask[WORD_BITS-1-b] = 1'b1;
          n = n + 1'b1;
        end else begin
          go = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.found = hit;
    res.pos   = p;
    res.run   = r;
    res.stop  = !go;
    res.cnt   = n;
    case (ctrl.op)
      WU_MARK:  res.data = data | mmask;
      WU_CLEAR: res.data = data & ~cmask;
      default:  res.data = data;
    endcase
  end

endmodule
